// File: rtl/mmfn_pkg.sv
// ============================================================================
// mmfn_pkg
// Shared types and constants for the min/max fitness normalizer.
// ============================================================================
package mmfn_pkg;

    localparam int FIT_W       = 17;
    localparam int IDX_W       = 6;
    localparam int QUO_STEPS   = 17;
    localparam int STEP_W      = 5;
    localparam int OUT_TDATA_W = 24;

    localparam logic [FIT_W-1:0] FIT_ONE = 17'h10000;

    typedef logic [FIT_W-1:0] fitness_t;
    typedef logic [IDX_W-1:0] index_t;

    typedef struct packed {
        logic [OUT_TDATA_W-FIT_W-IDX_W-1:0] pad;
        index_t                             item_index;
        fitness_t                           fitness;
    } out_tdata_t;

endpackage

// File: rtl/min_max_fitness_normalizer.sv
// ============================================================================
// min_max_fitness_normalizer
// Stores a set of distances, then emits (max-d)/(max-min) in Q1.16 per item.
// ============================================================================
//  channel | dir | tdata                        | tlast       | tuser
//  s_*     | in  | distance [DIST_WIDTH-1:0]    | last_item   | -
//  m_*     | out | fitness [16:0], index [22:17] | last_result | items_dropped
//
//  Loading: one input transfer per cycle, s_tready high while collecting.
//  After the transfer with tlast, each stored item goes through one RAM
//  read, one subtract, 17 steps of the shared restoring divider, one push.
//  m_tready low with a result pending holds the sequencer in the push step;
//  s_tready stays low until the final result is loaded into the output register.
//  Reset clears the set; RAM contents are only read after being written.
// ============================================================================
module min_max_fitness_normalizer #(
    parameter int MAX_ITEMS  = 64,
    parameter int DIST_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DIST_WIDTH+7)/8)*8-1:0]     s_tdata,  // distance
    input  logic                                s_tlast,  // last_item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmfn_pkg::OUT_TDATA_W-1:0]    m_tdata,  // fitness, item_index
    output logic                                m_tlast,  // last_result
    output logic                                m_tuser   // items_dropped
);

    import mmfn_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int W      = DIST_WIDTH;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [W-1:0]      min_reg, min_next;
    logic [W-1:0]      max_reg, max_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [W-1:0]      span_reg, span_next;
    logic [W:0]        rem_reg, rem_next;
    fitness_t          quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    out_tdata_t        m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    logic [W-1:0]      distance;
    logic              in_xfer;
    logic              has_room;
    logic              wr_en;
    logic              rd_en;
    logic [W-1:0]      rd_data;
    logic [W:0]        diff;
    logic              ge;
    logic [W:0]        rem_sel;
    logic              is_last;
    logic              out_free;
    logic              push;

    assign distance = s_tdata[W-1:0];
    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign has_room = (count_reg < CNT_W'(MAX_ITEMS));
    assign wr_en    = in_xfer && has_room;
    assign rd_en    = (state_reg == ST_READ);

    mmfn_ram #(
        .WIDTH (W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (distance),
        .rd_en   (rd_en),
        .rd_addr (k_reg),
        .rd_data (rd_data)
    );

    // shared divider step: compare/subtract against the span
    assign diff    = rem_reg - {1'b0, span_reg};
    assign ge      = (rem_reg >= {1'b0, span_reg});
    assign rem_sel = ge ? diff : rem_reg;

    assign is_last  = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign push     = (state_reg == ST_PUSH) && out_free;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        span_next     = span_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (distance < min_reg)
                        begin
                            min_next = distance;
                        end
                        if (distance > max_reg)
                        begin
                            max_next = distance;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        k_next     = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                span_next  = max_reg - min_reg;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                rem_next   = {1'b0, max_reg - rd_data};
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = {rem_sel[W-1:0], 1'b0};
                quo_next  = {quo_reg[FIT_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_STEPS - 1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (is_last)
                    begin
                        count_next = '0;
                        min_next   = '1;
                        max_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
            ovf_reg      <= 1'b0;
            k_reg        <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            ovf_reg      <= ovf_next;
            k_reg        <= k_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        if (push)
        begin
            m_tdata_reg.pad        <= '0;
            m_tdata_reg.item_index <= IDX_W'(k_reg);
            m_tdata_reg.fitness    <= (span_reg == '0) ? FIT_ONE : quo_reg;
            m_tlast_reg            <= is_last;
            m_tuser_reg            <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/mmfn_ram.sv
// ============================================================================
// mmfn_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mmfn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/mmfn_checker.sv
// ============================================================================
// mmfn_checker
// Port-level checks for the min/max fitness normalizer.
// ============================================================================
module mmfn_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mmfn_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tlast
);

    import mmfn_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // a result other than the final one is only shown while the sweep runs
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("collecting while a set is still being emitted");

    // an ordinary transfer keeps the block collecting
    a_keep_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("ready dropped mid-set");

    // closing transfer starts the output sweep
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready stayed high after set end");

endmodule

bind min_max_fitness_normalizer mmfn_checker u_mmfn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: bench/mmfn_fitness_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mmfn_fitness_checker
// Watches both stream channels of the fitness normalizer. It keeps its own
// copy of the stored set, the running min/max and the overflow flag, turns
// every closed set into the list of expected fitness results, and compares
// each output transfer with the oldest pending one, field by field.
// ============================================================================
module mmfn_fitness_checker #(
    parameter int MAX_ITEMS  = 64,
    parameter int DIST_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((DIST_WIDTH+7)/8)*8-1:0]     s_tdata,  // distance
    input  logic                                s_tlast,  // last_item
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mmfn_pkg::OUT_TDATA_W-1:0]    m_tdata,  // fitness, item_index
    input  logic                                m_tlast,  // last_result
    input  logic                                m_tuser,  // items_dropped
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_checked,
    output int                                  sets_closed,
    output int                                  overflow_sets
);
    import mmfn_pkg::*;

    typedef logic [DIST_WIDTH-1:0] dist_t;

    typedef struct {
        fitness_t fitness;
        index_t   item_index;
        logic     last_result;
        logic     items_dropped;
    } fitness_rec_t;

    fitness_rec_t pending_fitness_q[$];
    dist_t        route_mem [MAX_ITEMS];
    int           route_cnt;
    dist_t        shortest;
    dist_t        longest;
    logic         overflowed;

    // (hi - d) / (hi - lo) in Q1.16, truncated; 1.0 for a flat set
    function automatic fitness_t norm_fitness(dist_t d, dist_t lo, dist_t hi);
        logic [DIST_WIDTH+15:0] scaled;
        logic [DIST_WIDTH+15:0] span;
        if (hi == lo)
            return FIT_ONE;
        scaled = {hi - d, 16'h0000};
        span   = {16'h0000, hi - lo};
        return fitness_t'(scaled / span);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_check
        out_tdata_t   word;
        fitness_rec_t want;
        dist_t        d;
        if (!rst_n)
        begin
            pending_fitness_q.delete();
            route_cnt   = 0;
            shortest    = '1;
            longest     = '0;
            overflowed  = 1'b0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                word = out_tdata_t'(m_tdata);
                if (pending_fitness_q.size() == 0)
                begin
                    report_mismatch($sformatf("result for index %0d with none pending",
                                              word.item_index));
                end
                else
                begin
                    want = pending_fitness_q.pop_front();
                    results_checked++;
                    if (word.fitness !== want.fitness)
                        report_mismatch($sformatf("fitness of index %0d: got %0d, want %0d",
                                                  want.item_index, word.fitness, want.fitness));
                    if (word.item_index !== want.item_index)
                        report_mismatch($sformatf("item_index: got %0d, want %0d",
                                                  word.item_index, want.item_index));
                    if (m_tlast !== want.last_result)
                        report_mismatch($sformatf("last_result of index %0d: got %b, want %b",
                                                  want.item_index, m_tlast, want.last_result));
                    if (m_tuser !== want.items_dropped)
                        report_mismatch($sformatf("items_dropped of index %0d: got %b, want %b",
                                                  want.item_index, m_tuser,
                                                  want.items_dropped));
                end
            end

            if (s_tvalid && s_tready)
            begin
                d = s_tdata[DIST_WIDTH-1:0];
                if (route_cnt < MAX_ITEMS)
                begin
                    route_mem[route_cnt] = d;
                    if (d < shortest)
                        shortest = d;
                    if (d > longest)
                        longest = d;
                    route_cnt++;
                end
                else
                begin
                    overflowed = 1'b1;
                end

                if (s_tlast)
                begin
                    for (int k = 0; k < route_cnt; k++)
                    begin
                        want.fitness       = norm_fitness(route_mem[k], shortest, longest);
                        want.item_index    = index_t'(k);
                        want.last_result   = (k == route_cnt - 1);
                        want.items_dropped = overflowed;
                        pending_fitness_q.insert(pending_fitness_q.size(), want);
                    end
                    sets_closed++;
                    if (overflowed)
                        overflow_sets++;
                    route_cnt  = 0;
                    shortest   = '1;
                    longest    = '0;
                    overflowed = 1'b0;
                end
            end

            outstanding = pending_fitness_q.size();
        end
    end

endmodule

// File: bench/min_max_fitness_normalizer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// min_max_fitness_normalizer_tb
// Drives sets of route distances into the normalizer: a few hand-picked sets
// (extremes, single item, flat sets) followed by random sets of mixed
// spread, including full and over-capacity sets. Sender bursts and receiver
// stalls are random, with one long receiver hold-off. Checking is done by
// the checker instance; this module makes stimulus and gives the verdict.
// ============================================================================
module min_max_fitness_normalizer_tb;

    localparam int MAX_ITEMS    = 64;
    localparam int DIST_WIDTH   = 32;
    localparam int S_TDATA_W    = ((DIST_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;

    typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_EXTREME} spread_t;
    typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [S_TDATA_W-1:0]               s_tdata;   // distance
    logic                               s_tlast;   // last_item
    logic                               m_tvalid;
    logic                               m_tready;
    logic [mmfn_pkg::OUT_TDATA_W-1:0]   m_tdata;   // fitness, item_index
    logic                               m_tlast;   // last_result
    logic                               m_tuser;   // items_dropped

    int mismatches;
    int outstanding;
    int results_checked;
    int sets_closed;
    int overflow_sets;
    int distances_sent;
    int burst_left;
    int idle_cycles;

    min_max_fitness_normalizer #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIST_WIDTH (DIST_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    mmfn_fitness_checker #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIST_WIDTH (DIST_WIDTH)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .sets_closed     (sets_closed),
        .overflow_sets   (overflow_sets)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // no-progress watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: stall pattern by segments, one long hold-off early on
    initial
    begin : receiver
        int       seg_no;
        int       seg_len;
        rx_mode_t mode;
        seg_no   = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (seg_no == 3)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            else
            begin
                mode    = rx_mode_t'($urandom_range(0, 3));
                seg_len = $urandom_range(20, 200);
                repeat (seg_len)
                begin
                    @(negedge clk);
                    case (mode)
                        RX_OPEN:   m_tready <= 1'b1;
                        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                        RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                        default:   m_tready <= ($urandom_range(0, 7) == 0);
                    endcase
                end
            end
            seg_no++;
        end
    end

    // one distance transfer; called and returns at a falling edge
    task automatic send_item(input logic [DIST_WIDTH-1:0] d, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tdata  <= S_TDATA_W'(d);
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        distances_sent++;
    endtask

    task automatic send_random_set(input int len);
        spread_t               spread;
        logic [DIST_WIDTH-1:0] base;
        logic [DIST_WIDTH-1:0] d;
        int                    width;
        spread = spread_t'($urandom_range(0, 3));
        base   = $urandom;
        width  = $urandom_range(1, 4096);
        for (int i = 0; i < len; i++)
        begin
            case (spread)
                SPREAD_FULL:   d = $urandom;
                SPREAD_NARROW: d = base + $urandom_range(0, width);
                SPREAD_FLAT:   d = base;
                default:
                    case ($urandom_range(0, 2))
                        0:       d = '0;
                        1:       d = '1;
                        default: d = $urandom;
                    endcase
            endcase
            send_item(d, i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int set_no;
        int len;
        int pick;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        distances_sent = 0;
        burst_left     = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes in one set
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0001, 1'b1);
        // single-item set
        send_item(32'h1234_5678, 1'b1);
        // flat sets
        send_item(32'd7, 1'b0);
        send_item(32'd7, 1'b0);
        send_item(32'd7, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        // span of one at the top of the range
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b1);
        // alternating bit patterns
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'h0000_0003, 1'b0);
        send_item(32'hFFFF_FFFD, 1'b1);

        set_no = 0;
        while (distances_sent < 16 + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (set_no == 0)
                len = MAX_ITEMS + 2;       // overflow, last two items dropped
            else if (set_no == 1)
                len = MAX_ITEMS;           // exactly full
            else if (pick == 0)
                len = MAX_ITEMS;
            else if (pick == 1)
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            else
                len = $urandom_range(1, 12);
            send_random_set(len);
            set_no++;
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d distances in %0d sets (%0d over capacity), %0d fitness values checked",
                 distances_sent, sets_closed, overflow_sets, results_checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
rtl/mmfn_pkg.sv
rtl/mmfn_ram.sv
rtl/min_max_fitness_normalizer.sv
rtl/mmfn_checker.sv
bench/mmfn_fitness_checker.sv
bench/min_max_fitness_normalizer_tb.sv
